/* hw/rtl/assert_macros.svh */
// assertion helpers for the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/tpp_pkg.sv */
package tpp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_AF_LEN,
    PH_AF_SKIP,
    PH_SC,
    PH_SID,
    PH_LEN,
    PH_EXT
  } tpp_phase_t;

  localparam logic [2:0] ST_NO_PES    = 3'd0;
  localparam logic [2:0] ST_NO_SC     = 3'd1;
  localparam logic [2:0] ST_PES_PLAIN = 3'd2;
  localparam logic [2:0] ST_PES_EXT   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_BAD_MARK  = 3'd5;
  localparam logic [2:0] ST_BAD_SYNC  = 3'd6;
  localparam logic [2:0] ST_TRUNC     = 3'd7;

  localparam logic [7:0]  TS_LEAD_BYTE = 8'h47;
  localparam logic [23:0] START_CODE   = 24'h000001;
  localparam logic [1:0]  EXT_MARKER   = 2'b10;

  localparam int NUM_KINDS = 5;
  localparam logic [7:0] KIND_ID   [NUM_KINDS] = '{8'hBD, 8'hBE, 8'hBF, 8'hC0, 8'hE0};
  localparam logic [7:0] KIND_MASK [NUM_KINDS] = '{8'hFF, 8'hFF, 8'hFF, 8'hE0, 8'hF0};
  localparam logic       KIND_EXT  [NUM_KINDS] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  typedef struct packed {
    tpp_phase_t  phase;
    logic [7:0]  pos;
    logic [7:0]  skip;
    logic [31:0] hdr;
    logic [23:0] sc;
    logic [7:0]  sid;
    logic [15:0] len;
    logic [13:0] flags;
  } tpp_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] pid;
    logic        transport_error;
    logic        transport_prio;
    logic [1:0]  ts_scrambling;
    logic [1:0]  adapt_control;
    logic [3:0]  continuity;
    logic [7:0]  stream_kind;
    logic [15:0] pes_length;
    logic [13:0] pes_flag_bits;
    logic [7:0]  pes_hdr_length;
  } tpp_result_t;

endpackage

/* hw/rtl/tpp_parse_step.sv */
module tpp_parse_step import tpp_pkg::*; #(
  parameter int PACKET_BYTES = 188
) (
  input  logic        word_valid,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  input  tpp_state_t  st,
  output tpp_state_t  st_nxt,
  output logic        res_valid,
  output tpp_result_t res
);

  localparam logic [7:0] PKT_LAST = 8'(PACKET_BYTES);

  function automatic tpp_result_t mk_result(tpp_state_t s, logic [2:0] code,
                                            logic [7:0] hlen);
    tpp_result_t r;
    r.status          = code;
    r.pid             = s.hdr[20:8];
    r.transport_error = s.hdr[23];
    r.transport_prio  = s.hdr[21];
    r.ts_scrambling   = s.hdr[7:6];
    r.adapt_control   = s.hdr[5:4];
    r.continuity      = s.hdr[3:0];
    r.stream_kind     = s.sid;
    r.pes_length      = s.len;
    r.pes_flag_bits   = s.flags;
    r.pes_hdr_length  = hlen;
    return r;
  endfunction

  tpp_state_t  s;
  tpp_result_t r;
  logic        n;
  logic        hit;
  logic        ext;
  logic        after_af;

  always_comb begin
    s        = st;
    r        = '0;
    n        = 1'b0;
    hit      = 1'b0;
    ext      = 1'b0;
    after_af = 1'b0;
    if (word_valid) begin
      if (packet_start) begin
        if (s.phase != PH_IDLE) begin
          r = mk_result(s, ST_TRUNC, 8'd0);
          n = 1'b1;
        end
        s       = '0;
        s.phase = PH_HDR;
      end
      if (s.phase != PH_IDLE) begin
        if (s.pos != 8'hFF) begin
          s.pos = s.pos + 8'd1;
        end
        case (s.phase)
          PH_HDR: begin
            if (s.skip < 8'd3) begin
              s.sc   = {s.sc[15:0], data_byte};
              s.skip = s.skip + 8'd1;
            end else begin
              s.hdr  = {s.sc, data_byte};
              s.sc   = '0;
              s.skip = '0;
              if (s.hdr[31:24] != TS_LEAD_BYTE) begin
                r       = mk_result(s, ST_BAD_SYNC, 8'd0);
                n       = 1'b1;
                s.phase = PH_IDLE;
              end else if (s.hdr[5]) begin
                s.phase = PH_AF_LEN;
              end else begin
                after_af = 1'b1;
              end
            end
          end
          PH_AF_LEN: begin
            s.skip = data_byte;
            if (data_byte == 8'd0) begin
              after_af = 1'b1;
            end else begin
              s.phase = PH_AF_SKIP;
            end
          end
          PH_AF_SKIP: begin
            s.skip = s.skip - 8'd1;
            if (s.skip == 8'd0) begin
              after_af = 1'b1;
            end
          end
          PH_SC: begin
            s.sc   = {s.sc[15:0], data_byte};
            s.skip = s.skip + 8'd1;
            if (s.skip >= 8'd3) begin
              if (s.sc != START_CODE) begin
                r       = mk_result(s, ST_NO_SC, 8'd0);
                n       = 1'b1;
                s.phase = PH_IDLE;
              end else begin
                s.phase = PH_SID;
              end
              s.sc   = '0;
              s.skip = '0;
            end
          end
          PH_SID: begin
            s.sid   = data_byte;
            s.phase = PH_LEN;
            s.skip  = '0;
            s.sc    = '0;
          end
          PH_LEN: begin
            if (s.skip == 8'd0) begin
              s.sc   = {16'd0, data_byte};
              s.skip = 8'd1;
            end else begin
              s.len  = {s.sc[7:0], data_byte};
              s.sc   = '0;
              s.skip = '0;
              for (int i = NUM_KINDS - 1; i >= 0; i--) begin
                if ((s.sid & KIND_MASK[i]) == KIND_ID[i]) begin
                  hit = 1'b1;
                  ext = KIND_EXT[i];
                end
              end
              if (!hit) begin
                r       = mk_result(s, ST_UNKNOWN, 8'd0);
                n       = 1'b1;
                s.phase = PH_IDLE;
              end else if (!ext) begin
                r       = mk_result(s, ST_PES_PLAIN, 8'd0);
                n       = 1'b1;
                s.phase = PH_IDLE;
              end else begin
                s.phase = PH_EXT;
              end
            end
          end
          PH_EXT: begin
            if (s.skip == 8'd0) begin
              if (data_byte[7:6] != EXT_MARKER) begin
                r       = mk_result(s, ST_BAD_MARK, 8'd0);
                n       = 1'b1;
                s.phase = PH_IDLE;
              end else begin
                s.sc   = {18'd0, data_byte[5:0]};
                s.skip = 8'd1;
              end
            end else if (s.skip == 8'd1) begin
              s.flags = {s.sc[5:0], data_byte};
              s.sc    = '0;
              s.skip  = 8'd2;
            end else begin
              r       = mk_result(s, ST_PES_EXT, data_byte);
              n       = 1'b1;
              s.phase = PH_IDLE;
            end
          end
          default: begin
            s.phase = PH_IDLE;
          end
        endcase
        if (after_af) begin
          if (!s.hdr[22]) begin
            r       = mk_result(s, ST_NO_PES, 8'd0);
            n       = 1'b1;
            s.phase = PH_IDLE;
          end else begin
            s.phase = PH_SC;
            s.skip  = '0;
            s.sc    = '0;
          end
        end
        if (s.phase != PH_IDLE && s.pos >= PKT_LAST && !n) begin
          r       = mk_result(s, ST_TRUNC, 8'd0);
          n       = 1'b1;
          s.phase = PH_IDLE;
        end
      end
    end
    st_nxt    = s;
    res_valid = n;
    res       = r;
  end

endmodule

/* hw/rtl/ts_pes_header_parser_core.sv */
// output: a result is registered into out_r, or into skid_r while out_r is held by out_stall
// throughput: one byte per cycle while in_stall is low; at most one result per byte
// a two-entry output (register plus skid) takes stalls; in_stall rises only when both are full
// reset: synchronous, active low; parser idle waiting for packet start, output empty
`include "assert_macros.svh"

module ts_pes_header_parser_core import tpp_pkg::*; #(
  parameter int PACKET_BYTES = 188
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [12:0] out_pid,
  output logic        out_transport_error,
  output logic        out_transport_prio,
  output logic [1:0]  out_ts_scrambling,
  output logic [1:0]  out_adapt_control,
  output logic [3:0]  out_continuity,
  output logic [7:0]  out_stream_kind,
  output logic [15:0] out_pes_length,
  output logic [13:0] out_pes_flag_bits,
  output logic [7:0]  out_pes_hdr_length
);

  tpp_state_t  st_r;
  tpp_state_t  st_nxt;
  logic        res_valid;
  tpp_result_t res;
  logic        in_accept;
  logic        take;

  tpp_result_t out_r;
  logic        out_v_r;
  tpp_result_t skid_r;
  logic        skid_v_r;

  assign in_stall  = skid_v_r;
  assign in_accept = in_valid && !skid_v_r;
  assign take      = out_v_r && !out_stall;

  tpp_parse_step #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_step (
    .word_valid  (in_accept),
    .data_byte   (in_data_byte),
    .packet_start(in_packet_start),
    .st          (st_r),
    .st_nxt      (st_nxt),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (skid_v_r) begin
        if (take) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end
      end else if (!out_v_r || take) begin
        out_r   <= res;
        out_v_r <= res_valid;
      end else if (res_valid) begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign out_valid           = out_v_r;
  assign out_status          = out_r.status;
  assign out_pid             = out_r.pid;
  assign out_transport_error = out_r.transport_error;
  assign out_transport_prio  = out_r.transport_prio;
  assign out_ts_scrambling   = out_r.ts_scrambling;
  assign out_adapt_control   = out_r.adapt_control;
  assign out_continuity      = out_r.continuity;
  assign out_stream_kind     = out_r.stream_kind;
  assign out_pes_length      = out_r.pes_length;
  assign out_pes_flag_bits   = out_r.pes_flag_bits;
  assign out_pes_hdr_length  = out_r.pes_hdr_length;

  `TPP_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `TPP_ASSERT_IMP(a_open_within_packet, clk, rst_n, st_r.phase != PH_IDLE,
                  st_r.pos < 8'(PACKET_BYTES))
  `TPP_ASSERT_NXT(a_idle_needs_start, clk, rst_n,
                  st_r.phase == PH_IDLE && !(in_accept && in_packet_start),
                  st_r.phase == PH_IDLE)

endmodule
